[rtl/vghs_pkg.sv]
// Shared constants, types and codes of the volume gradient and Hessian stencil.
package vghs_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = XW + YW;
	localparam int DIM_W      = 9;
	localparam int DEPTH_W    = 16;
	localparam int CFG_W      = 16;
	localparam int PEND_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
	localparam int QDEPTH     = 8;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic signed [13:0] WG_CENTRE = 14'sd5069;
	localparam logic signed [13:0] WG_EDGE   = 14'sd4252;
	localparam logic signed [13:0] WG_CORNER = 14'sd2673;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH  = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	typedef logic [26:0][15:0] win_t;

	typedef struct packed {
		logic valid;
		logic inner;
		logic last;
	} ctrl_t;

	typedef struct packed {
		logic signed [32:0] gx;
		logic signed [32:0] gy;
		logic signed [32:0] gz;
		logic signed [21:0] hxx;
		logic signed [21:0] hyy;
		logic signed [21:0] hzz;
		logic signed [21:0] hxy;
		logic signed [21:0] hxz;
		logic signed [21:0] hyz;
		logic last;
	} res_t;

endpackage

[rtl/vghs_front.sv]
// Front end: counters, classification, plane and line stores, and the 3x3x3 window.
module vghs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_acc,
	input  logic                       op,
	input  logic signed [15:0]         smp,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [vghs_pkg::CFG_W-1:0] cfg_data,
	output logic                       emit,
	output vghs_pkg::win_t             win,
	output vghs_pkg::ctrl_t            ctrl
);
	import vghs_pkg::*;

	logic [DIM_W-1:0]   w_q, h_q;
	logic [DEPTH_W-1:0] d_q;
	logic [XW-1:0]      ix_q, ox_q;
	logic [YW-1:0]      iy_q, oy_q;
	logic [DEPTH_W-1:0] iz_q, oz_q;
	logic [PEND_W-1:0]  pend_q;
	logic [PEND_W-1:0]  lag;
	logic               inner, last, is_smp;
	logic [ADDR_W-1:0]  addr;

	logic [15:0] plane_a [MAX_WIDTH*MAX_HEIGHT];
	logic [15:0] plane_b [MAX_WIDTH*MAX_HEIGHT];
	logic [31:0] line0 [MAX_WIDTH];
	logic [31:0] line1 [MAX_WIDTH];
	logic [31:0] line2 [MAX_WIDTH];

	logic [15:0]       rd_a_q, rd_b_q;
	logic [31:0]       rd_l0_q, rd_l1_q, rd_l2_q;
	logic              smp_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [XW-1:0]     x_s1;
	logic [15:0]       sample_s1;
	ctrl_t             ctrl_s1, ctrl_s2;
	win_t              win_q;
	logic [15:0]       col [9];
	logic [DIM_W-1:0]  cfg_dim_w, cfg_dim_h;
	logic [DEPTH_W-1:0] cfg_dep;

	assign is_smp = (op == OP_SAMPLE);
	assign addr   = {iy_q, ix_q};
	assign lag    = PEND_W'(w_q) * PEND_W'(h_q) + PEND_W'(w_q) + PEND_W'(1);
	assign emit   = is_smp ? (pend_q == lag) : (pend_q != '0);

	assign inner = is_smp && (ox_q != '0) && (DIM_W'(ox_q) + DIM_W'(2) <= w_q)
		&& (oy_q != '0) && (DIM_W'(oy_q) + DIM_W'(2) <= h_q)
		&& (oz_q != '0) && ({1'b0, oz_q} + 17'd2 <= {1'b0, d_q});
	assign last = (DIM_W'(ox_q) == w_q - DIM_W'(1)) && (DIM_W'(oy_q) == h_q - DIM_W'(1))
		&& (oz_q == d_q - DEPTH_W'(1));

	always_comb begin
		if (cfg_data < CFG_W'(3))
			cfg_dim_w = DIM_W'(3);
		else if (cfg_data > CFG_W'(MAX_WIDTH))
			cfg_dim_w = DIM_W'(MAX_WIDTH);
		else
			cfg_dim_w = cfg_data[DIM_W-1:0];
		if (cfg_data < CFG_W'(3))
			cfg_dim_h = DIM_W'(3);
		else if (cfg_data > CFG_W'(MAX_HEIGHT))
			cfg_dim_h = DIM_W'(MAX_HEIGHT);
		else
			cfg_dim_h = cfg_data[DIM_W-1:0];
		cfg_dep = (cfg_data < CFG_W'(3)) ? DEPTH_W'(3) : cfg_data;
	end

	// Counters, pending count and registers; a register write restarts the stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= DIM_W'(MAX_WIDTH);
			h_q    <= DIM_W'(MAX_HEIGHT);
			d_q    <= DEPTH_W'(256);
			ix_q   <= '0;
			iy_q   <= '0;
			iz_q   <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			oz_q   <= '0;
			pend_q <= '0;
		end else if (cfg_we && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT
				|| cfg_idx == REG_DEPTH)) begin
			unique case (cfg_idx)
				REG_WIDTH:  w_q <= cfg_dim_w;
				REG_HEIGHT: h_q <= cfg_dim_h;
				default:    d_q <= cfg_dep;
			endcase
			ix_q   <= '0;
			iy_q   <= '0;
			iz_q   <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			oz_q   <= '0;
			pend_q <= '0;
		end else if (in_acc) begin
			if (is_smp) begin
				if (!emit)
					pend_q <= pend_q + PEND_W'(1);
				if (DIM_W'(ix_q) == w_q - DIM_W'(1)) begin
					ix_q <= '0;
					if (DIM_W'(iy_q) == h_q - DIM_W'(1)) begin
						iy_q <= '0;
						iz_q <= (iz_q == d_q - DEPTH_W'(1)) ? '0 : iz_q + DEPTH_W'(1);
					end else begin
						iy_q <= iy_q + YW'(1);
					end
				end else begin
					ix_q <= ix_q + XW'(1);
				end
			end else if (emit) begin
				pend_q <= pend_q - PEND_W'(1);
			end
			if (emit) begin
				if (DIM_W'(ox_q) == w_q - DIM_W'(1)) begin
					ox_q <= '0;
					if (DIM_W'(oy_q) == h_q - DIM_W'(1)) begin
						oy_q <= '0;
						oz_q <= (oz_q == d_q - DEPTH_W'(1)) ? '0 : oz_q + DEPTH_W'(1);
					end else begin
						oy_q <= oy_q + YW'(1);
					end
				end else begin
					ox_q <= ox_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1  <= 1'b0;
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			smp_s1        <= in_acc && is_smp;
			ctrl_s1.valid <= in_acc && emit;
			ctrl_s1.inner <= inner;
			ctrl_s1.last  <= last;
			ctrl_s2       <= ctrl_s1;
		end
	end

	// Each line word holds the rows one and two above, upper half nearest.
	always_ff @(posedge clk) begin
		if (in_acc && is_smp) begin
			rd_a_q    <= plane_a[addr];
			rd_b_q    <= plane_b[addr];
			rd_l0_q   <= line0[ix_q];
			rd_l1_q   <= line1[ix_q];
			rd_l2_q   <= line2[ix_q];
			addr_s1   <= addr;
			x_s1      <= ix_q;
			sample_s1 <= smp;
		end
		if (smp_s1) begin
			plane_a[addr_s1] <= sample_s1;
			plane_b[addr_s1] <= rd_a_q;
			line0[x_s1]      <= {rd_b_q, rd_l0_q[31:16]};
			line1[x_s1]      <= {rd_a_q, rd_l1_q[31:16]};
			line2[x_s1]      <= {sample_s1, rd_l2_q[31:16]};
		end
	end

	always_comb begin
		col[0] = rd_l0_q[15:0];
		col[1] = rd_l0_q[31:16];
		col[2] = rd_b_q;
		col[3] = rd_l1_q[15:0];
		col[4] = rd_l1_q[31:16];
		col[5] = rd_a_q;
		col[6] = rd_l2_q[15:0];
		col[7] = rd_l2_q[31:16];
		col[8] = sample_s1;
	end

	always_ff @(posedge clk) begin
		if (smp_s1) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
				win_q[k*3+2] <= col[k];
			end
		end
	end

	assign win  = win_q;
	assign ctrl = ctrl_s2;

endmodule

[rtl/vghs_calc.sv]
// Back end: three-stage pipeline that turns a window into derivatives.
module vghs_calc (
	input  logic            clk,
	input  logic            arst_n,
	input  vghs_pkg::win_t  win,
	input  vghs_pkg::ctrl_t ctrl,
	output logic            res_valid,
	output vghs_pkg::res_t  res
);
	import vghs_pkg::*;

	localparam int GA [3] = '{0, 1, 2};
	localparam int GB [3] = '{1, 0, 1};
	localparam int GC [3] = '{2, 2, 0};
	localparam int HA [3] = '{0, 1, 2};
	localparam int HB [3] = '{1, 0, 0};
	localparam int HC [3] = '{2, 2, 1};
	localparam int XA [3] = '{0, 0, 1};
	localparam int XB [3] = '{1, 2, 2};
	localparam int XC [3] = '{2, 1, 0};

	function automatic logic signed [15:0] tp(win_t w, int a, int sa, int b, int sb,
			int c, int sc);
		int o [3];
		o[a] = sa;
		o[b] = sb;
		o[c] = sc;
		return $signed(w[(o[2] + 1) * 9 + (o[1] + 1) * 3 + (o[0] + 1)]);
	endfunction

	function automatic logic signed [16:0] fd(win_t w, int a, int b, int sb, int c, int sc);
		return 17'(tp(w, a, 1, b, sb, c, sc)) - 17'(tp(w, a, -1, b, sb, c, sc));
	endfunction

	function automatic logic signed [18:0] sd(win_t w, int a, int b, int sb, int c, int sc);
		return 19'(tp(w, a, 1, b, sb, c, sc)) + 19'(tp(w, a, -1, b, sb, c, sc))
			- (19'(tp(w, a, 0, b, sb, c, sc)) <<< 1);
	endfunction

	function automatic logic signed [18:0] cd(win_t w, int a, int b, int c, int sc);
		return 19'(tp(w, a, 1, b, 1, c, sc)) + 19'(tp(w, a, -1, b, -1, c, sc))
			- 19'(tp(w, a, 1, b, -1, c, sc)) - 19'(tp(w, a, -1, b, 1, c, sc));
	endfunction

	logic signed [16:0] gcen_s1 [3];
	logic signed [18:0] gedg_s1 [3], gcor_s1 [3];
	logic signed [18:0] hcen_s1 [3];
	logic signed [20:0] hedg_s1 [3], hcor_s1 [3];
	logic signed [18:0] xm_s1 [3], xp_s1 [3], xn_s1 [3];
	logic signed [29:0] gpc_s2 [3];
	logic signed [31:0] gpe_s2 [3], gpk_s2 [3];
	logic signed [21:0] hd_s2 [3], hx_s2 [3];
	ctrl_t              ctrl_s1, ctrl_s2;
	logic               valid_s3;
	res_t               res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1  <= '0;
			ctrl_s2  <= '0;
			valid_s3 <= 1'b0;
		end else begin
			ctrl_s1  <= ctrl;
			ctrl_s2  <= ctrl_s1;
			valid_s3 <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			gcen_s1[i] <= fd(win, GA[i], GB[i], 0, GC[i], 0);
			gedg_s1[i] <= 19'(fd(win, GA[i], GB[i], 1, GC[i], 0))
				+ 19'(fd(win, GA[i], GB[i], -1, GC[i], 0))
				+ 19'(fd(win, GA[i], GB[i], 0, GC[i], 1))
				+ 19'(fd(win, GA[i], GB[i], 0, GC[i], -1));
			gcor_s1[i] <= 19'(fd(win, GA[i], GB[i], 1, GC[i], 1))
				+ 19'(fd(win, GA[i], GB[i], -1, GC[i], 1))
				+ 19'(fd(win, GA[i], GB[i], 1, GC[i], -1))
				+ 19'(fd(win, GA[i], GB[i], -1, GC[i], -1));
			hcen_s1[i] <= sd(win, HA[i], HB[i], 0, HC[i], 0);
			hedg_s1[i] <= 21'(sd(win, HA[i], HB[i], 1, HC[i], 0))
				+ 21'(sd(win, HA[i], HB[i], -1, HC[i], 0))
				+ 21'(sd(win, HA[i], HB[i], 0, HC[i], 1))
				+ 21'(sd(win, HA[i], HB[i], 0, HC[i], -1));
			hcor_s1[i] <= 21'(sd(win, HA[i], HB[i], 1, HC[i], 1))
				+ 21'(sd(win, HA[i], HB[i], -1, HC[i], 1))
				+ 21'(sd(win, HA[i], HB[i], 1, HC[i], -1))
				+ 21'(sd(win, HA[i], HB[i], -1, HC[i], -1));
			xm_s1[i] <= cd(win, XA[i], XB[i], XC[i], 0);
			xp_s1[i] <= cd(win, XA[i], XB[i], XC[i], 1);
			xn_s1[i] <= cd(win, XA[i], XB[i], XC[i], -1);
		end
		for (int i = 0; i < 3; i++) begin
			gpc_s2[i] <= 30'(gcen_s1[i]) * 30'(WG_CENTRE);
			gpe_s2[i] <= 32'(gedg_s1[i]) * 32'(WG_EDGE);
			gpk_s2[i] <= 32'(gcor_s1[i]) * 32'(WG_CORNER);
			hd_s2[i]  <= (22'(hcen_s1[i]) <<< 2) + (22'(hedg_s1[i]) <<< 1) + 22'(hcor_s1[i]);
			hx_s2[i]  <= (22'(xm_s1[i]) <<< 1) + 22'(xp_s1[i]) + 22'(xn_s1[i]);
		end
		// Face voxels and drain beats report zero derivatives.
		if (ctrl_s2.inner) begin
			res_s3.gx  <= 33'(gpc_s2[0]) + 33'(gpe_s2[0]) + 33'(gpk_s2[0]);
			res_s3.gy  <= 33'(gpc_s2[1]) + 33'(gpe_s2[1]) + 33'(gpk_s2[1]);
			res_s3.gz  <= 33'(gpc_s2[2]) + 33'(gpe_s2[2]) + 33'(gpk_s2[2]);
			res_s3.hxx <= hd_s2[0];
			res_s3.hyy <= hd_s2[1];
			res_s3.hzz <= hd_s2[2];
			res_s3.hxy <= hx_s2[0];
			res_s3.hxz <= hx_s2[1];
			res_s3.hyz <= hx_s2[2];
		end else begin
			res_s3.gx  <= '0;
			res_s3.gy  <= '0;
			res_s3.gz  <= '0;
			res_s3.hxx <= '0;
			res_s3.hyy <= '0;
			res_s3.hzz <= '0;
			res_s3.hxy <= '0;
			res_s3.hxz <= '0;
			res_s3.hyz <= '0;
		end
		res_s3.last <= ctrl_s2.last;
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule

[rtl/vghs_fifo.sv]
// Result queue between the arithmetic pipeline and the output port.
module vghs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vghs_pkg::res_t din,
	input  logic           pop,
	output logic           not_empty,
	output vghs_pkg::res_t dout
);
	import vghs_pkg::*;

	res_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_q] <= din;
	end

	assign not_empty = (cnt_q != '0);
	assign dout      = q_mem[rd_q];

endmodule

[rtl/volume_gradient_hessian_stencil.sv]
// Streaming 3x3x3 gradient and Hessian stencil over a raster-order signed 16-bit volume.
// The block takes one beat per cycle while in_stall is low, samples and drain ticks alike.
// Each result passes the front end and the arithmetic pipeline and waits in an eight-entry
// queue; the input stalls only when eight results are accepted but not yet taken. Two plane
// stores of 65536 x 16 bits hold the two previous planes and three 256 x 32-bit line stores
// hold the rows above; each store does one read and one write per cycle. Register writes
// take effect at once and restart the stream; the configuration port is always ready.
module volume_gradient_hessian_stencil (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic signed [15:0]         sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [32:0]         grad_x,
	output logic signed [32:0]         grad_y,
	output logic signed [32:0]         grad_z,
	output logic signed [21:0]         h_xx,
	output logic signed [21:0]         h_yy,
	output logic signed [21:0]         h_zz,
	output logic signed [21:0]         h_xy,
	output logic signed [21:0]         h_xz,
	output logic signed [21:0]         h_yz,
	output logic                       final_voxel,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [vghs_pkg::CFG_W-1:0] cfg_data
);
	import vghs_pkg::*;

	logic            in_acc, emit, out_pop, calc_valid;
	win_t            win;
	ctrl_t           ctrl;
	res_t            calc_res, head;
	logic [QPTR_W:0] resv_q;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_pop   = out_valid && !out_stall;

	// Queue slots are reserved when a result-bearing beat is accepted.
	assign in_stall = (resv_q == (QPTR_W+1)'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			resv_q <= '0;
		else if ((in_acc && emit) && !out_pop)
			resv_q <= resv_q + (QPTR_W+1)'(1);
		else if (!(in_acc && emit) && out_pop)
			resv_q <= resv_q - (QPTR_W+1)'(1);
	end

	vghs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.op       (operation),
		.smp      (sample),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_idx  (cfg_index),
		.cfg_data (cfg_data),
		.emit     (emit),
		.win      (win),
		.ctrl     (ctrl)
	);

	vghs_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win),
		.ctrl      (ctrl),
		.res_valid (calc_valid),
		.res       (calc_res)
	);

	vghs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (calc_valid),
		.din       (calc_res),
		.pop       (out_pop),
		.not_empty (out_valid),
		.dout      (head)
	);

	assign grad_x      = head.gx;
	assign grad_y      = head.gy;
	assign grad_z      = head.gz;
	assign h_xx        = head.hxx;
	assign h_yy        = head.hyy;
	assign h_zz        = head.hzz;
	assign h_xy        = head.hxy;
	assign h_xz        = head.hxz;
	assign h_yz        = head.hyz;
	assign final_voxel = head.last;

endmodule

[tb/tb.sv]
// Self-checking testbench for the volume gradient and Hessian stencil.
module tb;
	import vghs_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int ITEM_GOAL  = 1850;

	// Predicts the stencil results of each accepted beat and checks the block's output against them.
	class stencil_scoreboard;
		int unsigned       wd, ht, dp;
		shortint           plane_a[MAX_WIDTH * MAX_HEIGHT];
		shortint           plane_b[MAX_WIDTH * MAX_HEIGHT];
		shortint           rows[2 * MAX_WIDTH];
		int                win[27];
		longint unsigned   in_idx, out_idx;
		res_t              expected_q[$];
		int                errors;
		int                results_seen;

		function new();
			wd = 256;
			ht = 256;
			dp = 256;
			errors = 0;
			results_seen = 0;
			restart();
		endfunction

		function void restart();
			in_idx = 0;
			out_idx = 0;
			foreach (win[i]) win[i] = 0;
		endfunction

		function int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] v);
			case (idx)
				REG_WIDTH: wd = clampv(v, 3, MAX_WIDTH);
				REG_HEIGHT: ht = clampv(v, 3, MAX_HEIGHT);
				REG_DEPTH: dp = clampv(v, 3, 65535);
				default: return;
			endcase
			restart();
		endfunction

		function longint unsigned vol_size();
			return longint'(wd) * ht * dp;
		endfunction

		function longint unsigned backlog();
			longint unsigned vol;
			vol = vol_size();
			return (in_idx + vol - out_idx) % vol;
		endfunction

		function longint tap(int a, int sa, int b, int sb, int c, int sc);
			int o[3];
			o[a] = sa;
			o[b] = sb;
			o[c] = sc;
			return win[(o[2] + 1) * 9 + (o[1] + 1) * 3 + (o[0] + 1)];
		endfunction

		function longint fdiff(int a, int b, int sb, int c, int sc);
			return tap(a, 1, b, sb, c, sc) - tap(a, -1, b, sb, c, sc);
		endfunction

		function longint sdiff(int a, int b, int sb, int c, int sc);
			return tap(a, 1, b, sb, c, sc) + tap(a, -1, b, sb, c, sc)
				- 2 * tap(a, 0, b, sb, c, sc);
		endfunction

		function longint cdiff(int a, int b, int c, int sc);
			return tap(a, 1, b, 1, c, sc) + tap(a, -1, b, -1, c, sc)
				- tap(a, 1, b, -1, c, sc) - tap(a, -1, b, 1, c, sc);
		endfunction

		function longint grad(int a, int b, int c);
			longint e, k;
			e = fdiff(a, b, 1, c, 0) + fdiff(a, b, -1, c, 0)
				+ fdiff(a, b, 0, c, 1) + fdiff(a, b, 0, c, -1);
			k = fdiff(a, b, 1, c, 1) + fdiff(a, b, -1, c, 1)
				+ fdiff(a, b, 1, c, -1) + fdiff(a, b, -1, c, -1);
			return 5069 * fdiff(a, b, 0, c, 0) + 4252 * e + 2673 * k;
		endfunction

		function longint hdiag(int a, int b, int c);
			longint e, k;
			e = sdiff(a, b, 1, c, 0) + sdiff(a, b, -1, c, 0)
				+ sdiff(a, b, 0, c, 1) + sdiff(a, b, 0, c, -1);
			k = sdiff(a, b, 1, c, 1) + sdiff(a, b, -1, c, 1)
				+ sdiff(a, b, 1, c, -1) + sdiff(a, b, -1, c, -1);
			return 4 * sdiff(a, b, 0, c, 0) + 2 * e + k;
		endfunction

		function longint hcross(int a, int b, int c);
			return 2 * cdiff(a, b, c, 0) + cdiff(a, b, c, 1) + cdiff(a, b, c, -1);
		endfunction

		function void note_beat(logic op, logic signed [15:0] s);
			longint unsigned vol, lag, pend, x, y, p, q, cx, cy, cz;
			int col[3][3];
			bit inner;
			res_t r;
			vol = vol_size();
			lag = longint'(wd) * ht + wd + 1;
			inner = 0;
			if (op == OP_SAMPLE) begin
				x = in_idx % wd;
				y = (in_idx / wd) % ht;
				p = y * wd + x;
				foreach (col[i, j]) col[i][j] = 0;
				col[2][2] = s;
				col[2][1] = plane_a[p];
				col[2][0] = plane_b[p];
				if (y >= 1) begin
					q = p - wd;
					col[1][2] = plane_a[q];
					col[1][1] = plane_b[q];
					col[1][0] = rows[((y - 1) & 1) * MAX_WIDTH + x];
				end
				if (y >= 2) begin
					q = p - 2 * wd;
					col[0][2] = plane_a[q];
					col[0][1] = plane_b[q];
					col[0][0] = rows[(y & 1) * MAX_WIDTH + x];
				end
				rows[(y & 1) * MAX_WIDTH + x] = plane_b[p];
				plane_b[p] = plane_a[p];
				plane_a[p] = s;
				for (int dz = 0; dz < 3; dz++)
					for (int dy = 0; dy < 3; dy++) begin
						win[dz * 9 + dy * 3] = win[dz * 9 + dy * 3 + 1];
						win[dz * 9 + dy * 3 + 1] = win[dz * 9 + dy * 3 + 2];
						win[dz * 9 + dy * 3 + 2] = col[dy][dz];
					end
				in_idx = (in_idx + 1) % vol;
				pend = backlog();
				if (pend <= lag) return;
				cx = out_idx % wd;
				cy = (out_idx / wd) % ht;
				cz = out_idx / (longint'(wd) * ht);
				inner = cx >= 1 && cx + 2 <= wd && cy >= 1 && cy + 2 <= ht
					&& cz >= 1 && cz + 2 <= dp;
			end else if (backlog() == 0) begin
				return;
			end
			r = '0;
			if (inner) begin
				r.gx = grad(0, 1, 2);
				r.gy = grad(1, 0, 2);
				r.gz = grad(2, 1, 0);
				r.hxx = hdiag(0, 1, 2);
				r.hyy = hdiag(1, 0, 2);
				r.hzz = hdiag(2, 0, 1);
				r.hxy = hcross(0, 1, 2);
				r.hxz = hcross(0, 2, 1);
				r.hyz = hcross(1, 2, 0);
			end
			r.last = (out_idx == vol - 1);
			out_idx = (out_idx + 1) % vol;
			expected_q.push_back(r);
		endfunction

		function void check(res_t got);
			res_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected result %p", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.gx !== want.gx || got.gy !== want.gy || got.gz !== want.gz
				|| got.hxx !== want.hxx || got.hyy !== want.hyy || got.hzz !== want.hzz
				|| got.hxy !== want.hxy || got.hxz !== want.hxz || got.hyz !== want.hyz
				|| got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result %0d mismatch\n  expected %p\n  actual   %p",
						results_seen, want, got);
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               operation = OP_SAMPLE;
	logic signed [15:0] sample = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [32:0] grad_x, grad_y, grad_z;
	logic signed [21:0] h_xx, h_yy, h_zz, h_xy, h_xz, h_yz;
	logic               final_voxel;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	stencil_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int beats_sent = 0;
	int phases_run = 0;
	int quiet_cycles = 0;

	volume_gradient_hessian_stencil i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
		.h_xx(h_xx), .h_yy(h_yy), .h_zz(h_zz),
		.h_xy(h_xy), .h_xz(h_xz), .h_yz(h_yz),
		.final_voxel(final_voxel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.gx = grad_x;
			got.gy = grad_y;
			got.gz = grad_z;
			got.hxx = h_xx;
			got.hyy = h_yy;
			got.hzz = h_zz;
			got.hxy = h_xy;
			got.hxz = h_xz;
			got.hyz = h_yz;
			got.last = final_voxel;
			sb.check(got);
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	// A beat leaves in_valid high; the next beat or an explicit drop lowers it.
	task automatic push_beat(logic op, logic [15:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_beat(op, s);
		beats_sent++;
	endtask

	task automatic settle();
		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [15:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
	endtask

	task automatic flush_pending();
		while (sb.backlog() != 0) push_beat(OP_DRAIN, pick_sample());
	endtask

	initial begin
		logic [15:0] dims[3];
		int order[3];
		int tmp, k, total;
		longint unsigned vol;

		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Smallest volume: only its center voxel is inside, every other one is on a face.
		write_cfg(REG_WIDTH, 16'd3);
		write_cfg(REG_HEIGHT, 16'd3);
		write_cfg(REG_DEPTH, 16'd3);
		write_cfg(2'd3, 16'd5);
		cfg_valid <= 0;
		push_beat(OP_DRAIN, 16'h1234);
		for (int i = 0; i < 27; i++)
			push_beat(OP_SAMPLE, (i == 13) ? 16'h7fff : ((i % 2) ? 16'h8000 : 16'h7fff));
		flush_pending();

		while (beats_sent < ITEM_GOAL) begin
			settle();
			case (phases_run % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 58; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 58; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			case (phases_run % 9)
				3: begin dims[0] = 16'd256; dims[1] = 16'd3; dims[2] = 16'd3; end
				5: begin dims[0] = 16'd3; dims[1] = 16'hffff; dims[2] = 16'd3; end
				7: begin dims[0] = 16'd3; dims[1] = 16'd3; dims[2] = 16'hffff; end
				8: begin dims[0] = 16'd0; dims[1] = 16'd1; dims[2] = 16'd2; end
				default: begin
					dims[0] = 16'($urandom_range(3, 7));
					dims[1] = 16'($urandom_range(3, 7));
					dims[2] = 16'($urandom_range(3, 6));
				end
			endcase
			for (int i = 0; i < 3; i++) order[i] = i;
			for (int i = 2; i > 0; i--) begin
				k = $urandom_range(i);
				tmp = order[i];
				order[i] = order[k];
				order[k] = tmp;
			end
			for (int i = 0; i < 3; i++) write_cfg(2'(order[i]), dims[order[i]]);
			if ($urandom_range(3) == 0) write_cfg(2'd3, 16'($urandom));
			cfg_valid <= 0;

			vol = sb.vol_size();
			total = (vol <= 400) ? int'(vol) * $urandom_range(1, 2) : 300;
			for (int i = 0; i < total; i++) begin
				if (phases_run == 2 && i == total / 2) begin
					in_valid <= 0;
					while (sb.expected_q.size() != 0) @(posedge clk);
				end
				// A rare drain in mid volume emits one pending voxel with zero derivatives.
				if ($urandom_range(99) < 2) push_beat(OP_DRAIN, pick_sample());
				push_beat(OP_SAMPLE, pick_sample());
			end
			flush_pending();
			phases_run++;
		end

		settle();
		$display("Sent %0d beats over %0d volume settings; checked %0d results.",
			beats_sent, phases_run + 1, sb.results_seen);
		$display("Mismatches: %0d", sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
